// ===== src/lcr_pkg.sv =====
// shared types and constants of the load cell converter reader
package lcr_pkg;

	// default number of data bits clocked in per conversion
	localparam int DATA_BITS_DEF = 24;

	// field widths
	localparam int REQ_W    = 2;
	localparam int MODE_W   = 2;
	localparam int RAW_W    = 24;
	localparam int SUM_W    = RAW_W + 1;
	localparam int SCALE_W  = 16;
	localparam int SCALED_W = 41;
	localparam int CFG_W    = 24;
	localparam int IDX_W    = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_W  = 8;
	localparam int OUT_W = 72;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_MODE    = 2'd0;
	localparam logic [IDX_W-1:0] REG_ZERO_OFFSET  = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TARE    = 2'd2;

	// gain mode codes
	localparam logic [MODE_W-1:0] MODE_PWR_DOWN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_A128     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_B32      = 2'd2;
	localparam logic [MODE_W-1:0] MODE_A64      = 2'd3;

	// reset values: offset 37730 counts, scale 0.0321 in Q0.16
	localparam logic signed [RAW_W-1:0] OFFSET_RESET = 24'sd37730;
	localparam logic [SCALE_W-1:0]      SCALE_RESET  = 16'd2104;

	// 24-bit signed limits
	localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;
	localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh800000;

	// one half period as produced by the sequencer, before scaling
	typedef struct packed {
		logic                    sck;
		logic                    valid;
		logic                    stale;
		logic signed [RAW_W-1:0] raw;
		logic signed [SUM_W-1:0] sum;
		logic                    busy;
	} seq_res_t;

	// extra clock pulses after the data bits, selecting the next gain mode
	function automatic logic [1:0] extra_pulses(input logic [MODE_W-1:0] mode);
		logic [1:0] n;
		unique case (mode)
			MODE_A128: n = 2'd3;
			MODE_B32:  n = 2'd2;
			MODE_A64:  n = 2'd1;
			default:   n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== src/lcr_seq.sv =====
// readout sequencer: serial clock, bit capture, tare and offset state
module lcr_seq #(
	parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [lcr_pkg::REQ_W-1:0]   req_type,
	input  logic                        dout,
	input  logic                        cfg_we,
	input  logic [lcr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [lcr_pkg::CFG_W-1:0]   cfg_data,
	output lcr_pkg::seq_res_t           res
);
	import lcr_pkg::*;

	localparam int PCNT_W = $clog2(DATA_BITS + 4);

	typedef enum logic {PH_IDLE, PH_READ} phase_t;

	phase_t                    phase_q, phase_n;
	logic [PCNT_W-1:0]         pulse_q, pulse_n, pulse_inc, total;
	logic                      half_q, half_n;
	logic [DATA_BITS-1:0]      shift_q, shift_n, shift_upd;
	logic [MODE_W-1:0]         mode_q, mode_n;
	logic signed [RAW_W-1:0]   offset_q, offset_n;
	logic signed [RAW_W-1:0]   last_q, last_n;
	logic                      tare_q, tare_n;
	logic                      clk_q, clk_n;
	logic                      is_req;
	logic signed [32:0]        sx;
	logic signed [RAW_W-1:0]   raw_sat;
	logic                      pres, pres_stale, pres_tare;
	logic signed [RAW_W-1:0]   pres_raw;

	assign is_req    = (req_type == REQ_MEASURE) || (req_type == REQ_TARE);
	assign total     = PCNT_W'(DATA_BITS) + PCNT_W'(extra_pulses(mode_q));
	assign pulse_inc = pulse_q + 1'b1;
	assign shift_upd = (pulse_q < PCNT_W'(DATA_BITS)) ?
		{shift_q[DATA_BITS-2:0], dout} : shift_q;

	// sign-extend the captured word and clamp it to 24 bits
	assign sx = 33'(signed'(shift_upd));
	always_comb begin
		if (sx > 33'sd8388607)
			raw_sat = RAW_MAX;
		else if (sx < -33'sd8388608)
			raw_sat = RAW_MIN;
		else
			raw_sat = sx[RAW_W-1:0];
	end

	// next state and result of the half period being accepted
	always_comb begin
		phase_n    = phase_q;
		pulse_n    = pulse_q;
		half_n     = half_q;
		shift_n    = shift_q;
		mode_n     = mode_q;
		offset_n   = offset_q;
		last_n     = last_q;
		tare_n     = tare_q;
		clk_n      = clk_q;
		res        = '0;
		pres       = 1'b0;
		pres_stale = 1'b0;
		pres_tare  = 1'b0;
		pres_raw   = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_req) begin
					// a request wakes a powered-down converter into channel A gain 128
					mode_n = (mode_q == MODE_PWR_DOWN) ? MODE_A128 : mode_q;
					clk_n  = 1'b0;
					if (dout) begin
						pres       = 1'b1;
						pres_stale = 1'b1;
						pres_raw   = last_q;
						pres_tare  = (req_type == REQ_TARE);
					end else begin
						phase_n  = PH_READ;
						pulse_n  = '0;
						half_n   = 1'b0;
						shift_n  = '0;
						tare_n   = (req_type == REQ_TARE);
						res.busy = 1'b1;
					end
				end
				res.sck = clk_n;
			end
			PH_READ: begin
				if (!half_q) begin
					// high half of a pulse
					clk_n    = 1'b1;
					half_n   = 1'b1;
					res.sck  = 1'b1;
					res.busy = 1'b1;
				end else begin
					// low half: sample data, count the pulse
					clk_n   = 1'b0;
					half_n  = 1'b0;
					shift_n = shift_upd;
					pulse_n = pulse_inc;
					if (pulse_inc >= total) begin
						last_n = raw_sat;
						if (mode_q == MODE_PWR_DOWN)
							clk_n = 1'b1;
						phase_n   = PH_IDLE;
						pulse_n   = '0;
						pres      = 1'b1;
						pres_raw  = raw_sat;
						pres_tare = tare_q;
						tare_n    = 1'b0;
						res.sck   = clk_n;
					end else begin
						res.busy = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// present a reading; tare takes the negated reading afterwards
		if (pres) begin
			res.valid = 1'b1;
			res.stale = pres_stale;
			res.raw   = pres_raw;
			res.sum   = {offset_q[RAW_W-1], offset_q} + {pres_raw[RAW_W-1], pres_raw};
			if (pres_tare)
				offset_n = (pres_raw == RAW_MIN) ? RAW_MAX : -pres_raw;
		end
	end

	// state registers; configuration writes must come only while idle, which the block enforces only for the gain mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pulse_q  <= '0;
			half_q   <= 1'b0;
			shift_q  <= '0;
			mode_q   <= MODE_PWR_DOWN;
			offset_q <= OFFSET_RESET;
			last_q   <= '0;
			tare_q   <= 1'b0;
			clk_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_MODE: begin
					if (phase_q == PH_IDLE) begin
						mode_q <= cfg_data[MODE_W-1:0];
						clk_q  <= (cfg_data[MODE_W-1:0] == MODE_PWR_DOWN);
					end
				end
				REG_ZERO_OFFSET: offset_q <= signed'(cfg_data[RAW_W-1:0]);
				default: ;
			endcase
		end else if (step) begin
			phase_q  <= phase_n;
			pulse_q  <= pulse_n;
			half_q   <= half_n;
			shift_q  <= shift_n;
			mode_q   <= mode_n;
			offset_q <= offset_n;
			last_q   <= last_n;
			tare_q   <= tare_n;
			clk_q    <= clk_n;
		end
	end

endmodule

// ===== src/load_cell_adc_reader.sv =====
// top level of the load cell converter reader: stream ports, scaling stage
// Each input item is one half period of the converter's serial clock: the
// request and the sampled data pin. One item is accepted per clock cycle
// unless the output side stalls, and every item yields exactly one result item,
// via stage 1 and the output register. The sequencer updates its state in the cycle
// an item is accepted; the following stage multiplies the offset-corrected
// reading by the scale factor (25 x 17 bits) into the output register. A
// conversion takes 2 * (DATA_BITS + 1..3) items plus the starting item.
// The output register holds a result while the next item is taken in.
module load_cell_adc_reader #(
	parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [lcr_pkg::IN_W-1:0]  s_tdata,   // req_type[1:0], dout[2]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// sck[0], result_valid[1], stale[2], raw_value[26:3],
	// scaled_value[67:27], busy_res[68]
	output logic [lcr_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_we,
	input  logic [lcr_pkg::IDX_W-1:0] cfg_index,
	input  logic [lcr_pkg::CFG_W-1:0] cfg_data
);
	import lcr_pkg::*;

	seq_res_t                    seq_res, res_s1;
	logic                        v_s1;
	logic                        out_v_q;
	logic                        out_ready;
	logic                        step;
	logic [SCALE_W-1:0]          scale_q;
	logic signed [SUM_W+SCALE_W:0] prod;
	logic                        sck_q, valid_q, stale_q, busy_q;
	logic signed [RAW_W-1:0]     raw_q;
	logic signed [SCALED_W-1:0]  scaled_q;

	assign out_ready = !out_v_q || m_tready;
	assign s_tready  = !v_s1 || out_ready;
	assign step      = s_tvalid && s_tready;

	lcr_seq #(
		.DATA_BITS(DATA_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req_type (s_tdata[REQ_W-1:0]),
		.dout     (s_tdata[REQ_W]),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.res      (seq_res)
	);

	// scale factor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= SCALE_RESET;
		else if (cfg_we && cfg_index == REG_SCALE_FACTOR)
			scale_q <= cfg_data[SCALE_W-1:0];
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (step)
			v_s1 <= 1'b1;
		else if (out_ready)
			v_s1 <= 1'b0;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (step)
			res_s1 <= seq_res;
	end

	// offset-corrected reading times the unsigned scale
	assign prod = res_s1.sum * $signed({1'b0, scale_q});

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_ready)
			out_v_q <= v_s1;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_ready && v_s1) begin
			sck_q    <= res_s1.sck;
			valid_q  <= res_s1.valid;
			stale_q  <= res_s1.stale;
			busy_q   <= res_s1.busy;
			raw_q    <= res_s1.raw;
			scaled_q <= prod[SCALED_W-1:0];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, busy_q, scaled_q, raw_q, stale_q, valid_q, sck_q};

endmodule

// ===== src/lcr_checker.sv =====
// port-level checks of the load cell converter reader, bound to the top
module lcr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [lcr_pkg::OUT_W-1:0] m_tdata
);
	import lcr_pkg::*;

	// a stalled result item holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// stale only comes with a presented reading
	a_stale_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1])
		else $error("stale flag without a reading");

	// a reading ends the readout, so it never shows busy
	a_busy_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && m_tdata[68]))
		else $error("reading presented while busy");

	// without a reading the value fields are zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[67:3] == '0)
		else $error("value fields set without a reading");

	// padding bits above the fields stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:69] == 3'b000)
		else $error("padding bits set");

endmodule

bind load_cell_adc_reader lcr_checker u_lcr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== tb/sv/load_cell_reading_checker.sv =====
// checker for the load cell converter reader: predicts every result item and compares it
module load_cell_reading_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [lcr_pkg::IN_W-1:0]  s_tdata,   // req_type[1:0], dout[2]
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	// sck[0], result_valid[1], stale[2], raw_value[26:3],
	// scaled_value[67:27], busy_res[68]
	input  logic [lcr_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_we,
	input  logic [lcr_pkg::IDX_W-1:0] cfg_index,
	input  logic [lcr_pkg::CFG_W-1:0] cfg_data,
	output int                        pending,
	output int                        errors
);
	import lcr_pkg::*;

	localparam int NBITS = DATA_BITS_DEF;

	typedef enum logic {SEQ_IDLE, SEQ_READ} seq_phase_t;

	// one half period as seen on the result side
	typedef struct packed {
		logic                       sck;
		logic                       valid;
		logic                       stale;
		logic signed [RAW_W-1:0]    raw;
		logic signed [SCALED_W-1:0] scaled;
		logic                       busy;
	} reading_t;

	// register copies
	logic [MODE_W-1:0]       gain_reg;
	logic signed [RAW_W-1:0] offset_reg;
	logic [SCALE_W-1:0]      scale_reg;

	// sequencer copy
	seq_phase_t              seq_phase;
	int                      pulses;
	logic                    high_half;
	logic [RAW_W-1:0]        shifter;
	logic [MODE_W-1:0]       act_mode;
	logic signed [RAW_W-1:0] act_offset;
	logic signed [RAW_W-1:0] last_raw;
	logic                    tare_armed;
	logic                    sck_level;

	reading_t readings_due[$];
	int       fail_count;

	// presented reading; the scaled value uses the offset held before any tare
	function automatic reading_t emit_reading(input logic signed [RAW_W-1:0] raw,
			input logic stale, input logic tare);
		reading_t r;
		longint   prod;
		prod = (longint'(act_offset) + longint'(raw)) * longint'(scale_reg);
		r = '0;
		r.valid  = 1'b1;
		r.stale  = stale;
		r.raw    = raw;
		r.scaled = prod[SCALED_W-1:0];
		// tare keeps the negated reading, the most negative one saturating
		if (tare)
			act_offset = (raw == RAW_MIN) ? RAW_MAX : -raw;
		return r;
	endfunction

	// advance the sequencer copy by one half period of the serial clock
	function automatic reading_t next_half_period(input logic [REQ_W-1:0] req,
			input logic dout);
		reading_t r;
		int       total;
		r = '0;
		if (seq_phase == SEQ_IDLE) begin
			if (req == REQ_MEASURE || req == REQ_TARE) begin
				// a request wakes a powered-down converter on channel A gain 128
				if (act_mode == MODE_PWR_DOWN)
					act_mode = MODE_A128;
				sck_level = 1'b0;
				if (dout) begin
					r = emit_reading(last_raw, 1'b1, req == REQ_TARE);
				end else begin
					seq_phase  = SEQ_READ;
					pulses     = 0;
					high_half  = 1'b0;
					shifter    = '0;
					tare_armed = (req == REQ_TARE);
					r.busy     = 1'b1;
				end
			end
			r.sck = sck_level;
			return r;
		end

		// extra pulses after the data select the next gain
		case (act_mode)
			MODE_A128: total = NBITS + 3;
			MODE_B32:  total = NBITS + 2;
			MODE_A64:  total = NBITS + 1;
			default:   total = NBITS;
		endcase

		if (!high_half) begin
			sck_level = 1'b1;
			high_half = 1'b1;
			r.sck     = 1'b1;
			r.busy    = 1'b1;
			return r;
		end

		// low half: data pin sampled while data pulses remain
		sck_level = 1'b0;
		high_half = 1'b0;
		if (pulses < NBITS)
			shifter = {shifter[RAW_W-2:0], dout};
		pulses++;
		if (pulses >= total) begin
			last_raw = shifter;
			if (act_mode == MODE_PWR_DOWN)
				sck_level = 1'b1;
			seq_phase  = SEQ_IDLE;
			pulses     = 0;
			r          = emit_reading(last_raw, 1'b0, tare_armed);
			tare_armed = 1'b0;
			r.sck      = sck_level;
			return r;
		end
		r.busy = 1'b1;
		return r;
	endfunction

	task automatic compare_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want, got;
		if (!arst_n) begin
			gain_reg   = MODE_PWR_DOWN;
			offset_reg = OFFSET_RESET;
			scale_reg  = SCALE_RESET;
			seq_phase  = SEQ_IDLE;
			pulses     = 0;
			high_half  = 1'b0;
			shifter    = '0;
			act_mode   = MODE_PWR_DOWN;
			act_offset = OFFSET_RESET;
			last_raw   = '0;
			tare_armed = 1'b0;
			sck_level  = 1'b1;
			fail_count = 0;
			readings_due.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_MODE: begin
						gain_reg = cfg_data[MODE_W-1:0];
						// only an idle sequencer takes the new mode and clock level
						if (seq_phase == SEQ_IDLE) begin
							act_mode  = gain_reg;
							sck_level = (gain_reg == MODE_PWR_DOWN);
						end
					end
					REG_ZERO_OFFSET: begin
						offset_reg = cfg_data;
						act_offset = offset_reg;
					end
					REG_SCALE_FACTOR: scale_reg = cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end

			// result side first, so a stray result cannot meet its own item
			if (m_tvalid && m_tready) begin
				got.sck    = m_tdata[0];
				got.valid  = m_tdata[1];
				got.stale  = m_tdata[2];
				got.raw    = m_tdata[26:3];
				got.scaled = m_tdata[67:27];
				got.busy   = m_tdata[68];
				if (readings_due.size() == 0) begin
					$error("result item with no reading due");
					fail_count++;
				end else begin
					want = readings_due.pop_front();
					compare_field("sck", want.sck, got.sck);
					compare_field("result_valid", want.valid, got.valid);
					compare_field("stale", want.stale, got.stale);
					compare_field("raw_value", want.raw, got.raw);
					compare_field("scaled_value", want.scaled, got.scaled);
					compare_field("busy_res", want.busy, got.busy);
				end
			end

			if (s_tvalid && s_tready)
				readings_due.push_back(next_half_period(s_tdata[REQ_W-1:0], s_tdata[REQ_W]));
		end
		pending <= readings_due.size();
		errors  <= fail_count;
	end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the load cell converter reader testbench: clock, reset, stimulus and verdict
module testbench;
	import lcr_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 104;
	// request, 24 data pulses, up to 3 extra pulses and a spare idle half period
	localparam int READ_ITEMS  = 56;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 6;
	localparam int STUCK_LIMIT = 3000;

	localparam logic [REQ_W-1:0] REQ_SPARE  = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;

	int pending;
	int errors;
	int src_gap_pct    = 0;
	int sink_stall_pct = 0;
	bit hold_rx        = 1'b0;
	int n_sent         = 0;
	int stuck          = 0;

	always #2 clk = ~clk;

	load_cell_adc_reader u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	load_cell_reading_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	// offer one item, with random gaps ahead of it
	task automatic send_item(input logic [REQ_W-1:0] req, input logic dout);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - REQ_W - 1){1'b0}}, dout, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(REQ_TICK, 1'($urandom_range(1)));
	endtask

	function automatic logic [REQ_W-1:0] pick_request();
		return $urandom_range(1) ? REQ_TARE : REQ_MEASURE;
	endfunction

	// reading to clock in: zero, all ones, the signed range limits or a random code
	function automatic logic [RAW_W-1:0] pick_code();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return RAW_MIN;
			3: return RAW_MAX;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// well-formed readout: request, then the data bit on every low half period
	task automatic run_readout(input logic [RAW_W-1:0] code);
		int i;
		send_item(pick_request(), 1'b0);
		for (i = RAW_W - 1; i >= 0; i--) begin
			// requests while busy are ignored; mostly ticks with an odd stray one
			send_item(($urandom_range(9) == 0) ? REQ_W'($urandom_range(3)) : REQ_TICK,
				1'($urandom_range(1)));
			send_item(REQ_TICK, code[i]);
		end
		send_ticks(READ_ITEMS - 1 - 2 * RAW_W);
	endtask

	// readout start followed by fully random items, all within the busy window
	task automatic start_readout(input int n);
		send_item(pick_request(), 1'b0);
		repeat (n) send_item(REQ_W'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	// idle noise: ticks, the unused request code, requests finding the converter not ready
	task automatic run_idle_noise();
		logic [REQ_W-1:0] req;
		repeat ($urandom_range(1, 6)) begin
			req = REQ_W'($urandom_range(3));
			send_item(req, (req == REQ_MEASURE || req == REQ_TARE) ? 1'b1
				: 1'($urandom_range(1)));
		end
	endtask

	// sender stops until every result item has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// back-to-back writes of all registers, plus one to the unused index
	task automatic load_setup(input logic [MODE_W-1:0] gm, input logic [CFG_W-1:0] off,
			input logic [SCALE_W-1:0] sc);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAIN_MODE;
		cfg_data  <= {(CFG_W - MODE_W)'($urandom), gm};
		@(posedge clk);
		cfg_index <= REG_ZERO_OFFSET;
		cfg_data  <= off;
		@(posedge clk);
		cfg_index <= REG_SCALE_FACTOR;
		cfg_data  <= {(CFG_W - SCALE_W)'($urandom), sc};
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data  <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int                p;
		int                k;
		int                owed;
		int                phase_first;
		bit                held;
		logic [MODE_W-1:0] gm;
		logic [CFG_W-1:0]  off;
		logic [SCALE_W-1:0] sc;
		owed = 0;
		held = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: power-down ticks, unused code, not-ready measure and tare
		send_item(REQ_TICK, 1'b0);
		send_item(REQ_TICK, 1'b1);
		send_item(REQ_SPARE, 1'b0);
		send_item(REQ_MEASURE, 1'b1);
		send_item(REQ_TICK, 1'b0);
		send_item(REQ_TARE, 1'b1);
		send_item(REQ_MEASURE, 1'b1);
		send_item(REQ_SPARE, 1'b1);

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin gm = MODE_A128; off = '0; sc = '1; end
				1: begin gm = MODE_B32; off = RAW_MAX; sc = '0; end
				2: begin gm = MODE_A64; off = RAW_MIN; sc = '1; end
				3: begin gm = MODE_PWR_DOWN; off = CFG_W'($urandom); sc = SCALE_W'($urandom); end
				4: begin gm = MODE_PWR_DOWN; off = RAW_MIN; sc = '1; end
				default: begin
					gm  = MODE_W'($urandom_range(3));
					off = CFG_W'($urandom);
					sc  = SCALE_W'($urandom);
				end
			endcase
			load_setup(gm, off, sc);

			// idling: none, sender gaps, receiver stalls, both
			case (p % 4)
				0: begin src_gap_pct = 0; sink_stall_pct = 0; end
				1: begin src_gap_pct = 46; sink_stall_pct = 0; end
				2: begin src_gap_pct = 0; sink_stall_pct = 46; end
				default: begin src_gap_pct = 37; sink_stall_pct = 37; end
			endcase

			// finish a readout left running across the setup change
			send_ticks(owed);
			phase_first = n_sent;
			while (n_sent - phase_first < PHASE_ITEMS) begin
				// one long receiver hold-off while items keep coming
				if (p == 0 && !held && n_sent - phase_first >= 40) begin
					hold_rx = 1'b1;
					held    = 1'b1;
				end
				k = $urandom_range(99);
				if (k < 65) begin
					run_readout(pick_code());
				end else if (k < 80) begin
					k = $urandom_range(2 * RAW_W);
					start_readout(k);
					send_ticks(READ_ITEMS - 1 - k);
				end else begin
					run_idle_noise();
				end
			end

			// leave the converter mid-readout so the next setup lands while it is busy
			owed = 0;
			if (p < PHASES - 1 && $urandom_range(1)) begin
				k = $urandom_range(40);
				start_readout(k);
				owed = READ_ITEMS - 1 - k;
			end
		end

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
